/* rtl/dops_pkg.sv */
`default_nettype none
// Shared widths, types and a saturation helper for the decayed outer-product update core.
package dops_pkg;

   // Field widths of the request and response channels
   localparam int SLOT_IN_W = 3;
   localparam int IDX_IN_W  = 6;
   localparam int OP_W      = 16;
   localparam int ACC_W     = 32;

   // Fixed-point alignment: a = (k*v) >> 8, products with Q3.12 drop 12 bits,
   // products with the Q0.16 decay drop 16 bits
   localparam int A_SHIFT = 8;
   localparam int FRAC_IN = 12;
   localparam int W_FRAC  = 16;
   localparam int A_W     = 2 * OP_W - A_SHIFT;

   typedef logic signed [OP_W-1:0]  op_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [ACC_W:0]   sum_type;
   typedef logic signed [A_W-1:0]   a_type;

   localparam acc_type ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Item handed from the state stage to the column accumulator
   typedef struct packed {
      logic                 valid;
      logic                 last_row;
      logic [SLOT_IN_W-1:0] slot;
      logic [IDX_IN_W-1:0]  col;
      op_type               receptance;
      acc_type              t;
   } dops_stage_type;

   // Clamp a 33-bit sum to the signed 32-bit range
   function automatic acc_type sat_sum(input sum_type x);
      acc_type y;
      if (x[ACC_W] != x[ACC_W-1]) begin
         y = x[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         y = x[ACC_W-1:0];
      end
      return y;
   endfunction

endpackage
`default_nettype wire

/* rtl/dops_req_if.sv */
`default_nettype none
// Request channel: valid/ready handshake carrying one state element update.
interface dops_req_if import dops_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SLOT_IN_W-1:0] slot;
   logic [IDX_IN_W-1:0]  row;
   logic [IDX_IN_W-1:0]  col;
   op_type               receptance;
   op_type               key_elem;
   op_type               value_elem;
   op_type               bonus;
   logic [OP_W-1:0]      decay;
   logic                 last_row;

   modport source (
      output valid, slot, row, col, receptance, key_elem, value_elem, bonus, decay, last_row,
      input  ready
   );
   modport sink (
      input  valid, slot, row, col, receptance, key_elem, value_elem, bonus, decay, last_row,
      output ready
   );
endinterface
`default_nettype wire

/* rtl/dops_rsp_if.sv */
`default_nettype none
// Response channel: valid/ready handshake carrying one finished column output.
interface dops_rsp_if import dops_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SLOT_IN_W-1:0] out_slot;
   logic [IDX_IN_W-1:0]  out_col;
   acc_type              out_val;

   modport source (output valid, out_slot, out_col, out_val, input ready);
   modport sink (input valid, out_slot, out_col, out_val, output ready);
endinterface
`default_nettype wire

/* rtl/dops_accum.sv */
`default_nettype none
// Column accumulator: r*t product, accumulator memory with forwarding, response register.
module dops_accum import dops_pkg::*; #(
   parameter  int HEAD_SIZE = 64,
   localparam int HEAD_W    = (HEAD_SIZE > 1) ? $clog2(HEAD_SIZE) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dops_stage_type    stage_in,
   input  wire logic              clr_en,
   input  wire logic [HEAD_W-1:0] clr_idx,
   output logic                   advance,
   dops_rsp_if.source             rsp_chan
);

   localparam int PROD_W = OP_W + ACC_W;
   localparam int P_W    = PROD_W - FRAC_IN;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [P_W-1:0]    p_type;

   // Clamp the shifted r*t product to the signed 32-bit range
   function automatic acc_type sat_prod(input p_type x);
      acc_type y;
      if ((&x[P_W-1:ACC_W-1]) || !(|x[P_W-1:ACC_W-1])) begin
         y = x[ACC_W-1:0];
      end else begin
         y = x[P_W-1] ? ACC_MIN : ACC_MAX;
      end
      return y;
   endfunction

   dops_stage_type    s4_ff;
   prod_type          s4_prod_ff;
   acc_type           acc_rd_ff;
   logic              acc_fwd_ff;
   acc_type           acc_fwd_data_ff;
   acc_type           acc_mem [HEAD_SIZE];

   logic [HEAD_W-1:0] s3_idx;
   logic [HEAD_W-1:0] s4_idx;
   acc_type           s4_p;
   acc_type           acc_old;
   acc_type           acc_new;
   acc_type           acc_wd_pipe;
   logic              acc_we;
   logic [HEAD_W-1:0] acc_wa;
   acc_type           acc_wd;
   logic              emit;

   logic                 out_valid_ff;
   logic [SLOT_IN_W-1:0] out_slot_ff;
   logic [IDX_IN_W-1:0]  out_col_ff;
   acc_type              out_val_ff;

   assign s3_idx = HEAD_W'(stage_in.col);
   assign s4_idx = HEAD_W'(s4_ff.col);

   // Hold the whole pipe only when a result must leave and the response register is blocked
   assign emit    = s4_ff.valid && s4_ff.last_row;
   assign advance = !(emit && out_valid_ff && !rsp_chan.ready);

   // Advance into the accumulate stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff <= '0;
      end else if (advance) begin
         s4_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_prod_ff      <= prod_type'(stage_in.receptance) * prod_type'(stage_in.t);
         acc_fwd_ff      <= s4_ff.valid && (s4_idx == s3_idx);
         acc_fwd_data_ff <= acc_wd_pipe;
      end
   end

   // Accumulate; the last row of a column empties its accumulator
   assign s4_p        = sat_prod(s4_prod_ff[PROD_W-1:FRAC_IN]);
   assign acc_old     = acc_fwd_ff ? acc_fwd_data_ff : acc_rd_ff;
   assign acc_new     = sat_sum(sum_type'(acc_old) + sum_type'(s4_p));
   assign acc_wd_pipe = s4_ff.last_row ? '0 : acc_new;

   // Accumulator memory: one write, one registered read
   assign acc_we = clr_en || (advance && s4_ff.valid);
   assign acc_wa = clr_en ? clr_idx : s4_idx;
   assign acc_wd = clr_en ? '0 : acc_wd_pipe;

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_rd_ff <= acc_mem[s3_idx];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_slot_ff <= s4_ff.slot;
         out_col_ff  <= s4_ff.col;
         out_val_ff  <= acc_new;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_slot = out_slot_ff;
   assign rsp_chan.out_col  = out_col_ff;
   assign rsp_chan.out_val  = out_val_ff;

   a_rsp_from_last_row: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s4_ff.valid && s4_ff.last_row))
      else $error("response raised without a last-row request");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !advance |-> (out_valid_ff && !rsp_chan.ready))
      else $error("pipeline held while the response register was free");

   a_clear_without_traffic: assert property (@(posedge clock) disable iff (reset)
      clr_en |-> !s4_ff.valid)
      else $error("accumulator clear overlaps a pipeline write");

endmodule
`default_nettype wire

/* rtl/decayed_outer_product_state_update_core.sv */
`default_nettype none
// Path: a request is registered through stage 1, stage 2, stage 3, the accumulate stage and
// the response register. Throughput: one request per cycle while the response register is not
// blocked; a request that hits the same state element as the request accepted just before it is
// held off until that one leaves stage 1 (state read-modify-write loop). Reset: synchronous; a
// clearing pass zeroes the state and column accumulators, with no request accepted meanwhile.
module decayed_outer_product_state_update_core import dops_pkg::*; #(
   parameter int SLOTS     = 8,
   parameter int HEAD_SIZE = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dops_req_if.sink   req_chan,
   dops_rsp_if.source rsp_chan
);

   localparam int DEPTH  = SLOTS * HEAD_SIZE * HEAD_SIZE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HEAD_W = (HEAD_SIZE > 1) ? $clog2(HEAD_SIZE) : 1;
   localparam int SUM_W  = ADDR_W + 1;
   localparam int AU_W   = A_W + OP_W;
   localparam int SW_W   = ACC_W + OP_W + 1;

   localparam logic [SUM_W-1:0]  PLANE     = SUM_W'(HEAD_SIZE * HEAD_SIZE);
   localparam logic [SUM_W-1:0]  LINE      = SUM_W'(HEAD_SIZE);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] HEAD_END  = ADDR_W'(HEAD_SIZE);

   typedef logic signed [AU_W-1:0] au_type;
   typedef logic signed [SW_W-1:0] sw_type;

   // Index wrap tables
   logic [SLOT_IN_W-1:0] slot_wrap [2**SLOT_IN_W];
   logic [IDX_IN_W-1:0]  idx_wrap  [2**IDX_IN_W];

   for (genvar g = 0; g < 2**SLOT_IN_W; g++) begin : g_slot_wrap
      assign slot_wrap[g] = SLOT_IN_W'(g % SLOTS);
   end

   for (genvar g = 0; g < 2**IDX_IN_W; g++) begin : g_idx_wrap
      assign idx_wrap[g] = IDX_IN_W'(g % HEAD_SIZE);
   end

   logic [SLOT_IN_W-1:0] in_slot;
   logic [IDX_IN_W-1:0]  in_row;
   logic [IDX_IN_W-1:0]  in_col;
   logic [SUM_W-1:0]     in_addr_sum;
   logic [ADDR_W-1:0]    in_addr;
   logic                 advance;
   logic                 hazard;
   logic                 accept;

   // Clearing pass
   logic                 clr_active_ff;
   logic [ADDR_W-1:0]    clr_cnt_ff;
   logic [ADDR_W-1:0]    clr_cnt_in;
   logic                 clr_acc_en;

   // Stage 1: operands, k*v product, state read
   logic                 s1_valid_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic [SLOT_IN_W-1:0] s1_slot_ff;
   logic [IDX_IN_W-1:0]  s1_col_ff;
   op_type               s1_r_ff;
   op_type               s1_u_ff;
   logic [OP_W-1:0]      s1_w_ff;
   logic                 s1_last_ff;
   acc_type              s1_kv_ff;
   acc_type              st_rd_ff;
   logic                 st_fwd_ff;
   acc_type              st_fwd_data_ff;
   a_type                s1_a;
   acc_type              s1_st;

   // Stage 2: a*u and S*w products, state write-back
   logic                 s2_valid_ff;
   logic [ADDR_W-1:0]    s2_addr_ff;
   logic [SLOT_IN_W-1:0] s2_slot_ff;
   logic [IDX_IN_W-1:0]  s2_col_ff;
   op_type               s2_r_ff;
   logic                 s2_last_ff;
   a_type                s2_a_ff;
   acc_type              s2_st_ff;
   au_type               s2_au_prod_ff;
   sw_type               s2_sw_prod_ff;
   acc_type              s2_au;
   acc_type              s2_t;
   acc_type              s2_new_st;

   // Stage 3 hand-off to the accumulator
   dops_stage_type       s3_ff;

   // State memory port
   acc_type              state_mem [DEPTH];
   logic                 st_we;
   logic [ADDR_W-1:0]    st_wa;
   acc_type              st_wd;

   // Wrap indices and form the flat state address
   assign in_slot     = slot_wrap[req_chan.slot];
   assign in_row      = idx_wrap[req_chan.row];
   assign in_col      = idx_wrap[req_chan.col];
   assign in_addr_sum = SUM_W'(in_slot) * PLANE + SUM_W'(in_row) * LINE + SUM_W'(in_col);
   assign in_addr     = in_addr_sum[ADDR_W-1:0];

   // Hold off a request whose element is still in flight one stage ahead
   assign hazard         = s1_valid_ff && (s1_addr_ff == in_addr);
   assign req_chan.ready = advance && !clr_active_ff && !hazard;
   assign accept         = req_chan.valid && req_chan.ready;

   // Sweep the state memory and accumulators after reset
   assign clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
   assign clr_acc_en = clr_active_ff && (clr_cnt_ff < HEAD_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else if (clr_active_ff) begin
         if (clr_cnt_ff == LAST_ADDR) begin
            clr_active_ff <= 1'b0;
         end else begin
            clr_cnt_ff <= clr_cnt_in;
         end
      end
   end

   // Stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_addr_ff     <= in_addr;
         s1_slot_ff     <= in_slot;
         s1_col_ff      <= in_col;
         s1_r_ff        <= req_chan.receptance;
         s1_u_ff        <= req_chan.bonus;
         s1_w_ff        <= req_chan.decay;
         s1_last_ff     <= req_chan.last_row;
         s1_kv_ff       <= acc_type'(req_chan.key_elem) * acc_type'(req_chan.value_elem);
         st_fwd_ff      <= s2_valid_ff && (s2_addr_ff == in_addr);
         st_fwd_data_ff <= s2_new_st;
      end
   end

   // State memory: one write, one registered read
   assign st_we = clr_active_ff || (advance && s2_valid_ff);
   assign st_wa = clr_active_ff ? clr_cnt_ff : s2_addr_ff;
   assign st_wd = clr_active_ff ? '0 : s2_new_st;

   always_ff @(posedge clock) begin
      if (st_we) begin
         state_mem[st_wa] <= st_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_rd_ff <= state_mem[in_addr];
      end
   end

   // Take the forwarded write-back where the read raced it
   assign s1_a  = s1_kv_ff[ACC_W-1:A_SHIFT];
   assign s1_st = st_fwd_ff ? st_fwd_data_ff : st_rd_ff;

   // Stage 2 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_addr_ff    <= s1_addr_ff;
         s2_slot_ff    <= s1_slot_ff;
         s2_col_ff     <= s1_col_ff;
         s2_r_ff       <= s1_r_ff;
         s2_last_ff    <= s1_last_ff;
         s2_a_ff       <= s1_a;
         s2_st_ff      <= s1_st;
         s2_au_prod_ff <= au_type'(s1_a) * au_type'(s1_u_ff);
         s2_sw_prod_ff <= sw_type'(s1_st) * sw_type'($signed({1'b0, s1_w_ff}));
      end
   end

   // t = S + a*u, and the decayed state S*w + a
   assign s2_au     = acc_type'($signed(s2_au_prod_ff[AU_W-1:FRAC_IN]));
   assign s2_t      = sat_sum(sum_type'(s2_st_ff) + sum_type'(s2_au));
   assign s2_new_st = sat_sum(sum_type'($signed(s2_sw_prod_ff[ACC_W+W_FRAC-1:W_FRAC]))
                              + sum_type'(s2_a_ff));

   // Stage 3 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff <= '0;
      end else if (advance) begin
         s3_ff.valid      <= s2_valid_ff;
         s3_ff.last_row   <= s2_last_ff;
         s3_ff.slot       <= s2_slot_ff;
         s3_ff.col        <= s2_col_ff;
         s3_ff.receptance <= s2_r_ff;
         s3_ff.t          <= s2_t;
      end
   end

   dops_accum #(
      .HEAD_SIZE (HEAD_SIZE)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .stage_in (s3_ff),
      .clr_en   (clr_acc_en),
      .clr_idx  (clr_cnt_ff[HEAD_W-1:0]),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

   a_clear_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("request in flight during the clearing pass");

   a_clear_stays_done: assert property (@(posedge clock) disable iff (reset)
      !clr_active_ff |=> !clr_active_ff)
      else $error("clearing pass restarted without reset");

   a_no_adjacent_same_element: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff) |-> (s1_addr_ff != s2_addr_ff))
      else $error("back-to-back requests on one state element slipped the interlock");

   a_stall_holds_stage2: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(s2_addr_ff) && $stable(s2_valid_ff)))
      else $error("stage 2 moved while the pipeline was held");

endmodule
`default_nettype wire
